FILE: rtl/core/multi_axis_dds_step_generator_defines.svh
// Assertion macros shared by the step generator RTL.
`ifndef MULTI_AXIS_DDS_STEP_GENERATOR_DEFINES_SVH
`define MULTI_AXIS_DDS_STEP_GENERATOR_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MADS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MADS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mads_pkg.sv
// Shared constants and types of the step generator.
package mads_pkg;

  localparam int ACC_W        = 32;
  localparam int CMD_W        = 32;
  localparam int SCALE_W      = 24;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = CMD_W + SCALE_W;
  localparam int FIELD_JOINTS = 6;
  localparam int MASK_W       = FIELD_JOINTS;
  localparam int IN_BITS      = MASK_W + FIELD_JOINTS * CMD_W;
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 2 * FIELD_JOINTS + FIELD_JOINTS * ACC_W;
  localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;

  localparam int DEF_NUM_JOINTS = 6;
  localparam int DEF_STEP_BIT   = 22;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(6871948);

  typedef struct packed {
    logic load;
    logic fire;
    logic make;
  } lane_ctl_t;

endpackage

FILE: rtl/core/multi_axis_dds_step_generator.sv
// Top level of the multi-axis DDS step generator.
// One tick beat is taken every clock cycle unless a waiting result beat holds a full scaling
// stage, and each tick gives one result beat: the first stage holds the registered 32x24 command
// scaling of every joint, the second the per-joint accumulator add and step detection (none on
// reset ticks, which alternate and clear step bits), whose feedback loop sets the rate. Result
// fields are read straight from the joint state, which holds while a result beat waits.
`include "multi_axis_dds_step_generator_defines.svh"
module multi_axis_dds_step_generator #(
  parameter int NUM_JOINTS = mads_pkg::DEF_NUM_JOINTS,
  parameter int STEP_BIT   = mads_pkg::DEF_STEP_BIT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mads_pkg::SCALE_W-1:0]   cfg_wr_data,   // freq_scale
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // enable_mask, freq_cmd_0 .. freq_cmd_5
  input  logic [mads_pkg::IN_W-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // step_bits, dir_bits, feedback_0 .. feedback_5
  output logic [mads_pkg::OUT_W-1:0]     out_tdata
);
  import mads_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic               s1_valid_r;
  logic               phase_reset_next_r;
  logic               adv;
  lane_ctl_t          ctl;

  logic [NUM_JOINTS-1:0]            step_hits;
  logic [NUM_JOINTS-1:0]            dirs;
  logic [NUM_JOINTS-1:0][ACC_W-1:0] feedbacks;

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv || !s1_valid_r;
  assign ctl.load  = in_tready;
  assign ctl.fire  = adv && s1_valid_r;
  assign ctl.make  = !phase_reset_next_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r            <= SCALE_RESET;
      s1_valid_r         <= 1'b0;
      phase_reset_next_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scale_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (ctl.fire) begin
        phase_reset_next_r <= !phase_reset_next_r;
      end
    end
  end

  for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_lane
    logic [CMD_W-1:0] cmd;
    logic             en;
    if (j < FIELD_JOINTS) begin : g_field
      assign cmd = in_tdata[MASK_W + j*CMD_W +: CMD_W];
      assign en  = in_tdata[j];
    end else begin : g_spare
      assign cmd = '0;
      assign en  = 1'b0;
    end

    mads_lane #(
      .STEP_BIT (STEP_BIT)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .scale    (scale_r),
      .cmd      (cmd),
      .en       (en),
      .step_hit (step_hits[j]),
      .dir      (dirs[j]),
      .feedback (feedbacks[j])
    );
  end

  mads_merge #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .adv        (adv),
    .src_valid  (s1_valid_r),
    .step_hits  (step_hits),
    .dirs       (dirs),
    .feedbacks  (feedbacks),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  `MADS_ASSERT_SAME(a_no_fire_on_stall, clk, rst_n, out_tvalid && !out_tready, !ctl.fire, "tick processed while result beat stalled")
  `MADS_ASSERT_NEXT(a_reset_phase_clears, clk, rst_n, ctl.fire && !ctl.make, out_tvalid && (out_tdata[FIELD_JOINTS-1:0] == '0), "step bits not cleared on reset phase")
  `MADS_ASSERT_NEXT(a_phase_alternates, clk, rst_n, ctl.fire, phase_reset_next_r != $past(phase_reset_next_r), "phase did not alternate")

endmodule

FILE: rtl/core/mads_lane.sv
// One joint: registered command scaling, phase accumulator and step detection.
module mads_lane #(
  parameter int STEP_BIT = mads_pkg::DEF_STEP_BIT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mads_pkg::lane_ctl_t         ctl,
  input  logic [mads_pkg::SCALE_W-1:0] scale,
  input  logic [mads_pkg::CMD_W-1:0]  cmd,
  input  logic                        en,
  output logic                        step_hit,
  output logic                        dir,
  output logic [mads_pkg::ACC_W-1:0]  feedback
);
  import mads_pkg::*;

  logic              neg_r;
  logic              en_r;
  logic [PROD_W-1:0] prod_r;
  logic [CMD_W-1:0]  mag;
  logic [PROD_W-1:0] prod_nxt;

  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  fb_r;
  logic              dir_r;

  logic [PROD_W-FRAC_W-1:0] quot;
  logic [ACC_W-1:0]         add;
  logic [ACC_W-1:0]         sum;
  logic                     toggle;
  logic                     upd;

  assign mag      = cmd[CMD_W-1] ? (~cmd + CMD_W'(1)) : cmd;
  assign prod_nxt = PROD_W'(mag) * PROD_W'(scale);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg_r  <= cmd[CMD_W-1];
      en_r   <= en;
      prod_r <= prod_nxt;
    end
  end

  assign quot = prod_r[PROD_W-1:FRAC_W];

  always_comb begin
    if (!neg_r) begin
      add = (|quot[PROD_W-FRAC_W-1:ACC_W-1]) ? {1'b0, {(ACC_W-1){1'b1}}} : quot[ACC_W-1:0];
    end else begin
      add = (|quot[PROD_W-FRAC_W-1:ACC_W-1]) ? {1'b1, {(ACC_W-1){1'b0}}}
                                             : (~quot[ACC_W-1:0] + ACC_W'(1));
    end
  end

  assign sum      = acc_r + add;
  assign toggle   = acc_r[STEP_BIT] ^ sum[STEP_BIT];
  assign upd      = ctl.fire && ctl.make && en_r;
  assign step_hit = upd && toggle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      fb_r  <= '0;
      dir_r <= 1'b0;
    end else if (upd) begin
      acc_r <= sum;
      if (toggle) begin
        fb_r  <= sum;
        dir_r <= (add != '0) && !add[ACC_W-1];
      end
    end
  end

  assign dir      = dir_r;
  assign feedback = fb_r;

endmodule

FILE: rtl/core/mads_merge.sv
// Merge of lane results into step bits and the output beat.
module mads_merge #(
  parameter int NUM_JOINTS = mads_pkg::DEF_NUM_JOINTS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mads_pkg::lane_ctl_t                    ctl,
  input  logic                                   adv,
  input  logic                                   src_valid,
  input  logic [NUM_JOINTS-1:0]                  step_hits,
  input  logic [NUM_JOINTS-1:0]                  dirs,
  input  logic [NUM_JOINTS-1:0][mads_pkg::ACC_W-1:0] feedbacks,
  output logic                                   out_tvalid,
  output logic [mads_pkg::OUT_W-1:0]             out_tdata
);
  import mads_pkg::*;

  logic [NUM_JOINTS-1:0] step_r;
  logic [NUM_JOINTS-1:0] step_nxt;
  logic                  valid_r;

  logic [FIELD_JOINTS-1:0]            step_f;
  logic [FIELD_JOINTS-1:0]            dir_f;
  logic [FIELD_JOINTS-1:0][ACC_W-1:0] fb_f;

  assign step_nxt = ctl.make ? (step_r | step_hits) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (ctl.fire) begin
        step_r <= step_nxt;
      end
      if (adv) begin
        valid_r <= src_valid;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < FIELD_JOINTS; j++) begin
      if (j < NUM_JOINTS) begin
        step_f[j] = step_r[j];
        dir_f[j]  = dirs[j];
        fb_f[j]   = feedbacks[j];
      end else begin
        step_f[j] = 1'b0;
        dir_f[j]  = 1'b0;
        fb_f[j]   = '0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, fb_f, dir_f, step_f};

endmodule

FILE: sim/multi_axis_dds_step_generator_test.sv
// Self-checking testbench for the multi-axis DDS step generator.
module multi_axis_dds_step_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mads_pkg::*;

  localparam int JOINTS         = FIELD_JOINTS;
  localparam int STEP_POS       = DEF_STEP_BIT;
  localparam int RESULT_LATENCY = 2;
  localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
  localparam int IDLE_LIMIT     = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_TICKS   = 1300;

  localparam logic [CMD_W-1:0] CMD_MAX  = 32'h7FFF_FFFF;
  localparam logic [CMD_W-1:0] CMD_MIN  = 32'h8000_0000;
  localparam logic [CMD_W-1:0] CMD_STEP = 32'd40000;

  localparam logic [SCALE_W-1:0] SCALE_MAX   = '1;
  localparam logic [SCALE_W-1:0] SCALE_UNITY = SCALE_W'(1 << FRAC_W);
  localparam logic [SCALE_W-1:0] SCALE_HALF  = SCALE_W'(1 << (FRAC_W - 1));

  // enable_mask, freq_cmd_0 .. freq_cmd_5 from the lowest bit up
  typedef struct packed {
    logic [JOINTS-1:0][CMD_W-1:0] freq_cmd;
    logic [MASK_W-1:0]            enable_mask;
  } tick_t;

  // step_bits, dir_bits, feedback_0 .. feedback_5 from the lowest bit up
  typedef struct packed {
    logic [JOINTS-1:0][ACC_W-1:0] feedback;
    logic [JOINTS-1:0]            dir_bits;
    logic [JOINTS-1:0]            step_bits;
  } step_report_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [SCALE_W-1:0] cfg_wr_data;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;

  multi_axis_dds_step_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // joint state as the block should hold it
  logic                         reset_phase_next;
  logic [JOINTS-1:0][ACC_W-1:0] phase_acc;
  logic [JOINTS-1:0]            step_state;
  logic [JOINTS-1:0]            dir_state;
  logic [JOINTS-1:0][ACC_W-1:0] feedback_state;
  logic [SCALE_W-1:0]           freq_scale;

  step_report_t due_reports[$];
  int           fail_count;
  int           idle_cycles;
  bit           sender_gaps_on;
  int           burst_left;
  int           hold_request;
  int           hold_left;
  int           rx_mode;
  int           rx_mode_left;
  int           rx_phase;
  step_report_t seen_report;
  step_report_t want_report;

  function automatic logic [ACC_W-1:0] scaled_increment(input logic [CMD_W-1:0] cmd,
                                                        input logic [SCALE_W-1:0] scale);
    logic [63:0] mag;
    logic [63:0] prod;
    mag  = cmd[CMD_W-1] ? {32'd0, (~cmd + 32'd1)} : {32'd0, cmd};
    prod = (mag * {40'd0, scale}) >> FRAC_W;
    if (!cmd[CMD_W-1]) return (prod > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
    if (prod >= 64'h8000_0000) return 32'h8000_0000;
    return ~prod[31:0] + 32'd1;
  endfunction

  task automatic dds_tick(input tick_t t);
    step_report_t     r;
    logic [ACC_W-1:0] inc;
    logic [ACC_W-1:0] prior;
    if (!reset_phase_next) begin
      for (int j = 0; j < JOINTS; j++) begin
        if (t.enable_mask[j]) begin
          inc          = scaled_increment(t.freq_cmd[j], freq_scale);
          prior        = phase_acc[j];
          phase_acc[j] = prior + inc;
          if (prior[STEP_POS] != phase_acc[j][STEP_POS]) begin
            dir_state[j]      = !inc[ACC_W-1] && (inc != '0);
            step_state[j]     = 1'b1;
            feedback_state[j] = phase_acc[j];
          end
        end
      end
      reset_phase_next = 1'b1;
    end else begin
      step_state       = '0;
      reset_phase_next = 1'b0;
    end
    r.step_bits = step_state;
    r.dir_bits  = dir_state;
    r.feedback  = feedback_state;
    due_reports.push_back(r);
  endtask

  function automatic logic [CMD_W-1:0] rand_cmd();
    logic [CMD_W-1:0] mag;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return CMD_MAX;
          1: return CMD_MIN;
          2: return '0;
          3: return 32'd1;
          default: return '1;
        endcase
      end
      default: begin
        mag = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? (~mag + 32'd1) : mag;
      end
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.enable_mask = ($urandom_range(0, 3) == 0) ? '1 : MASK_W'($urandom);
    for (int j = 0; j < JOINTS; j++) t.freq_cmd[j] = rand_cmd();
    return t;
  endfunction

  function automatic tick_t uniform_tick(input logic [MASK_W-1:0] mask,
                                         input logic [CMD_W-1:0] cmd);
    tick_t t;
    t.enable_mask = mask;
    for (int j = 0; j < JOINTS; j++) t.freq_cmd[j] = cmd;
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    if (sender_gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'(t);
    do @(posedge clk); while (!in_tready);
    dds_tick(t);
  endtask

  task automatic wait_all_reported();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    wait_all_reported();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    freq_scale = value;
  endtask

  task automatic test_directed_extremes();
    tick_t t;
    sender_gaps_on = 1'b0;
    send_tick(uniform_tick('0, CMD_MAX));
    send_tick(uniform_tick('1, '0));
    repeat (2) send_tick(uniform_tick('1, CMD_STEP));
    repeat (2) send_tick(uniform_tick('1, ~CMD_STEP + 32'd1));
    repeat (2) send_tick(uniform_tick('1, CMD_MAX));
    repeat (2) send_tick(uniform_tick('1, CMD_MIN));
    repeat (2) send_tick(uniform_tick('1, '1));
    repeat (2) send_tick(uniform_tick('1, 32'd1));
    send_tick(uniform_tick(6'h2A, CMD_STEP));
    send_tick(uniform_tick(6'h15, ~CMD_STEP + 32'd1));
    t.enable_mask = '1;
    t.freq_cmd    = {CMD_MIN, CMD_MAX, 32'hFFFF_FFFF, 32'd0, ~CMD_STEP + 32'd1, CMD_STEP};
    repeat (2) send_tick(t);
  endtask

  task automatic test_scale_settings();
    logic [SCALE_W-1:0] scales[6];
    scales = '{'0, SCALE_W'(1), SCALE_HALF, SCALE_UNITY, SCALE_MAX, SCALE_W'($urandom)};
    foreach (scales[s]) begin
      write_scale(scales[s]);
      sender_gaps_on = (s % 2) == 1;
      send_tick(uniform_tick('1, 32'hFFFF_FFFD));
      send_tick(uniform_tick('1, CMD_MIN));
      send_tick(uniform_tick('1, CMD_MAX));
      send_tick(uniform_tick('1, 32'h0040_0000));
      repeat (16) send_tick(rand_tick());
    end
  endtask

  task automatic test_input_backpressure();
    write_scale(SCALE_W'($urandom_range(1, 1 << 17)));
    sender_gaps_on = 1'b0;
    @(negedge clk);
    hold_request = LONG_HOLD;
    repeat (40) send_tick(rand_tick());
    wait_all_reported();
    repeat (20) send_tick(rand_tick());
  endtask

  task automatic test_random_ticks();
    for (int n = 0; n < RANDOM_TICKS; n++) begin
      if (n % 250 == 0) begin
        case ($urandom_range(0, 5))
          0: write_scale(SCALE_MAX);
          1: write_scale('0);
          2: write_scale(SCALE_RESET);
          3: write_scale(SCALE_W'($urandom));
          default: write_scale(SCALE_W'($urandom_range(1, 1 << 18)));
        endcase
      end
      if (n % 100 == 0) sender_gaps_on = $urandom_range(0, 3) != 0;
      send_tick(rand_tick());
    end
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(10, 80);
      end
      rx_mode_left--;
      rx_phase++;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_phase % 5) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_report = step_report_t'(out_tdata[OUT_BITS-1:0]);
      if (due_reports.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        fail_count++;
      end else begin
        want_report = due_reports.pop_front();
        if (seen_report.step_bits !== want_report.step_bits) begin
          $error("step_bits: expected %h, got %h", want_report.step_bits, seen_report.step_bits);
          fail_count++;
        end
        if (seen_report.dir_bits !== want_report.dir_bits) begin
          $error("dir_bits: expected %h, got %h", want_report.dir_bits, seen_report.dir_bits);
          fail_count++;
        end
        for (int j = 0; j < JOINTS; j++) begin
          if (seen_report.feedback[j] !== want_report.feedback[j]) begin
            $error("feedback_%0d: expected %h, got %h", j, want_report.feedback[j],
                   seen_report.feedback[j]);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("multi_axis_dds_step_generator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_tvalid        = 1'b0;
    in_tdata         = '0;
    out_tready       = 1'b0;
    fail_count       = 0;
    idle_cycles      = 0;
    sender_gaps_on   = 1'b0;
    burst_left       = 0;
    hold_request     = 0;
    hold_left        = 0;
    rx_mode          = 0;
    rx_mode_left     = 0;
    rx_phase         = 0;
    reset_phase_next = 1'b0;
    phase_acc        = '0;
    step_state       = '0;
    dir_state        = '0;
    feedback_state   = '0;
    freq_scale       = SCALE_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_scale_settings();
    test_input_backpressure();
    test_random_ticks();
    wait_all_reported();

    if (due_reports.size() != 0) begin
      $error("%0d result beats never arrived", due_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("multi_axis_dds_step_generator verification clean");
    end else begin
      $display("multi_axis_dds_step_generator verification failed");
    end
    $finish;
  end

endmodule
